// File: rtl/sem_pkg.sv
// Shared types, constants and column helper functions for the Sobel edge magnitude block.
// Depends on nothing; sem_col_cell and sobel_edge_magnitude in rtl/ import it.
`timescale 1ns / 1ps
`default_nettype none

package sem_pkg;

    // Fixed field widths.
    localparam int PIX_W    = 8;
    localparam int CFG_W    = 11;
    localparam int OUT_XY_W = 10;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 32;

    // Defaults and limits.
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam logic [CFG_W-1:0] DIM_RESET = 11'd1024;
    localparam int MIN_DIM  = 3;
    localparam logic [PIX_W-1:0] EDGE_MAX = 8'd255;

    // Register indexes, taken from paddr[2].
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // One image column of the 3x3 window.
    typedef struct packed {
        logic [PIX_W-1:0] bot;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] top;
    } column_t;

    // Weighted column sum top + 2*mid + bot, used for the horizontal gradient.
    function automatic logic [PIX_W+1:0] col_sum(input column_t c);
        col_sum = {2'b00, c.top} + {1'b0, c.mid, 1'b0} + {2'b00, c.bot};
    endfunction

    // Column difference top - bot, used for the vertical gradient.
    function automatic logic signed [PIX_W:0] col_diff(input column_t c);
        col_diff = $signed({1'b0, c.top}) - $signed({1'b0, c.bot});
    endfunction

endpackage

`default_nettype wire

// File: rtl/sem_line_buf.sv
// One line buffer: a single-port-write, single-port-read memory with registered read data.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none

module sem_line_buf #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 8
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, read-first, data held until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/sem_col_cell.sv
// One window cell: holds one image column and passes it to the next cell on every shift.
// Depends on sem_pkg for the column type and the column sum and difference functions.
`timescale 1ns / 1ps
`default_nettype none

module sem_col_cell (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              shift_en,
    input  wire sem_pkg::column_t                  col_in,
    output sem_pkg::column_t                       col_out,
    output logic            [sem_pkg::PIX_W+1:0]   col_sum_out,
    output logic signed     [sem_pkg::PIX_W:0]     col_diff_out
);

    import sem_pkg::*;

    column_t col_reg;

    // Take the neighbour's column whenever a word leaves the read stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else if (shift_en) begin
            col_reg <= col_in;
        end
    end

    assign col_out      = col_reg;
    assign col_sum_out  = col_sum(col_reg);
    assign col_diff_out = col_diff(col_reg);

endmodule

`default_nettype wire

// File: rtl/sobel_edge_magnitude.sv
// Top level of the streaming 3x3 Sobel edge magnitude block.
// Depends on sem_pkg, sem_line_buf and sem_col_cell.
//
// Usage: grey pixels enter on the s_ stream in raster order, one word per
// cycle, pixel in s_tdata[7:0] and s_tuser set on pixel (0,0) of a new image.
// For each pixel at column x >= 1 and row y >= 1 one result word leaves on the
// m_ stream for the centre (x-1, y-1): m_tdata carries the saturated |dx|+|dy|,
// zero when the centre is on the top row or left column; m_tlast marks the
// centre (W-2, H-2). Image width and height are written over the APB port
// (byte addresses 0 and 4); the user must write them only while the block is idle,
// which the block does not enforce. They are used clamped to [3, MAX_WIDTH] and
// [3, MAX_HEIGHT]. A result passes through the read stage, where both line
// buffers are read, and then through the output register.
// Throughput: one pixel per cycle while the receiver takes results, set by the
// single read and write port of each line buffer; the window is a chain of two
// column cells that shift once per pixel.
// Reset clears the counters, the window, the pipeline valids and sets both
// dimensions to 1024; line buffers are not cleared. When the receiver stalls,
// the output register holds its word and one further pixel waits in the read
// stage; s_tready then drops until the output word is taken.
`timescale 1ns / 1ps
`default_nettype none

module sobel_edge_magnitude #(
    parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Input stream.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [sem_pkg::TDATA_IN_W-1:0]    s_tdata,   // [7:0] pixel
    input  wire logic                              s_tuser,   // [0] frame_start
    // Result stream.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [sem_pkg::TDATA_OUT_W-1:0]        m_tdata,   // [7:0] edge_value,
                                                              // [17:8] out_x,
                                                              // [27:18] out_y, rest 0
    output logic                                   m_tlast,   // frame_last
    // Configuration port.
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [sem_pkg::APB_AW-1:0]        paddr,
    input  wire logic [sem_pkg::APB_DW-1:0]        pwdata,
    output logic [sem_pkg::APB_DW-1:0]             prdata,
    output logic                                   pready
);

    import sem_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int EWW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int EWH = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

    // ------------------------------------------------------------------
    // Configuration registers.
    logic [CFG_W-1:0] width_cfg_reg;
    logic [CFG_W-1:0] height_cfg_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= DIM_RESET;
            height_cfg_reg <= DIM_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_IMAGE_WIDTH) begin
                width_cfg_reg <= pwdata[CFG_W-1:0];
            end else begin
                height_cfg_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_IMAGE_WIDTH) begin
            prdata[CFG_W-1:0] = width_cfg_reg;
        end else begin
            prdata[CFG_W-1:0] = height_cfg_reg;
        end
    end

    // Dimensions clamped into their legal ranges.
    logic [EWW-1:0] w_ext;
    logic [EWW-1:0] w_lim;
    logic [EWH-1:0] h_ext;
    logic [EWH-1:0] h_lim;

    always_comb begin
        w_ext = EWW'(width_cfg_reg);
        h_ext = EWH'(height_cfg_reg);
        if (w_ext < EWW'(MIN_DIM)) begin
            w_lim = EWW'(MIN_DIM);
        end else if (w_ext > EWW'(MAX_WIDTH)) begin
            w_lim = EWW'(MAX_WIDTH);
        end else begin
            w_lim = w_ext;
        end
        if (h_ext < EWH'(MIN_DIM)) begin
            h_lim = EWH'(MIN_DIM);
        end else if (h_ext > EWH'(MAX_HEIGHT)) begin
            h_lim = EWH'(MAX_HEIGHT);
        end else begin
            h_lim = h_ext;
        end
    end

    // ------------------------------------------------------------------
    // Handshake and pipeline control.
    logic s1_valid_reg;
    logic m_valid_reg;
    logic out_free;
    logic s1_leave;
    logic s_accept;

    assign out_free = !m_valid_reg || m_tready;
    assign s1_leave = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Position counters, advanced on each accepted word.
    logic [CW-1:0] col_count_reg;
    logic [CW-1:0] col_count_next;
    logic [RW-1:0] row_count_reg;
    logic [RW-1:0] row_count_next;
    logic [CW-1:0] x_cur;
    logic [RW-1:0] y_cur;
    logic          x_end;
    logic          y_end;

    always_comb begin
        x_cur = s_tuser ? '0 : col_count_reg;
        y_cur = s_tuser ? '0 : row_count_reg;
        x_end = (EWW'(x_cur) + EWW'(1)) >= w_lim;
        y_end = (EWH'(y_cur) + EWH'(1)) >= h_lim;
        if (x_end) begin
            col_count_next = '0;
            row_count_next = y_end ? '0 : y_cur + RW'(1);
        end else begin
            col_count_next = x_cur + CW'(1);
            row_count_next = y_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else if (s_accept) begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // ------------------------------------------------------------------
    // Read stage: the pixel waits here while both line buffers are read.
    logic [PIX_W-1:0] s1_pix_reg;
    logic [CW-1:0]    s1_addr_reg;
    logic             s1_emit_reg;
    logic             s1_border_reg;
    logic             s1_last_reg;
    logic [CW-1:0]    s1_cx_reg;
    logic [RW-1:0]    s1_cy_reg;
    logic             s1_fwd_reg;
    logic [PIX_W-1:0] s1_fwd_t_reg;
    logic [PIX_W-1:0] s1_fwd_m_reg;
    logic             fwd_next;
    column_t          col_right;
    logic [PIX_W-1:0] prev2_rd;
    logic [PIX_W-1:0] prev_rd;

    // A write to the same column as the new read bypasses the memory.
    assign fwd_next = s1_leave && (s1_addr_reg == x_cur);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_leave) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_pix_reg    <= s_tdata[PIX_W-1:0];
            s1_addr_reg   <= x_cur;
            s1_emit_reg   <= (x_cur != '0) && (y_cur != '0);
            s1_border_reg <= (x_cur == CW'(1)) || (y_cur == RW'(1));
            s1_last_reg   <= x_end && y_end;
            s1_cx_reg     <= x_cur - CW'(1);
            s1_cy_reg     <= y_cur - RW'(1);
            s1_fwd_reg    <= fwd_next;
            s1_fwd_t_reg  <= col_right.mid;
            s1_fwd_m_reg  <= col_right.bot;
        end
    end

    // Newest column: rows y-2, y-1 and y.
    always_comb begin
        col_right.top = s1_fwd_reg ? s1_fwd_t_reg : prev2_rd;
        col_right.mid = s1_fwd_reg ? s1_fwd_m_reg : prev_rd;
        col_right.bot = s1_pix_reg;
    end

    // Line buffers: row y-2 and row y-1.
    sem_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW),
        .DW    (PIX_W)
    ) u_line_prev2 (
        .aclk    (aclk),
        .wr_en   (s1_leave),
        .wr_addr (s1_addr_reg),
        .wr_data (col_right.mid),
        .rd_en   (s_accept),
        .rd_addr (x_cur),
        .rd_data (prev2_rd)
    );

    sem_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW),
        .DW    (PIX_W)
    ) u_line_prev (
        .aclk    (aclk),
        .wr_en   (s1_leave),
        .wr_addr (s1_addr_reg),
        .wr_data (col_right.bot),
        .rd_en   (s_accept),
        .rd_addr (x_cur),
        .rd_data (prev_rd)
    );

    // ------------------------------------------------------------------
    // Window: chain of two column cells, centre then left.
    column_t                  col_centre;
    column_t                  col_left;
    logic [PIX_W+1:0]         centre_sum;
    logic [PIX_W+1:0]         left_sum;
    logic signed [PIX_W:0]    centre_diff;
    logic signed [PIX_W:0]    left_diff;

    sem_col_cell u_cell_centre (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .shift_en     (s1_leave),
        .col_in       (col_right),
        .col_out      (col_centre),
        .col_sum_out  (centre_sum),
        .col_diff_out (centre_diff)
    );

    sem_col_cell u_cell_left (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .shift_en     (s1_leave),
        .col_in       (col_centre),
        .col_out      (col_left),
        .col_sum_out  (left_sum),
        .col_diff_out (left_diff)
    );

    // ------------------------------------------------------------------
    // Gradient magnitude, saturated.
    logic [PIX_W+1:0]         right_sum;
    logic signed [PIX_W:0]    right_diff;
    logic signed [PIX_W+2:0]  grad_x;
    logic signed [PIX_W+2:0]  grad_y;
    logic [PIX_W+1:0]         abs_x;
    logic [PIX_W+1:0]         abs_y;
    logic [PIX_W+2:0]         mag_sum;
    logic [PIX_W-1:0]         edge_val;

    always_comb begin
        right_sum  = col_sum(col_right);
        right_diff = col_diff(col_right);
        grad_x = $signed({1'b0, left_sum}) - $signed({1'b0, right_sum});
        grad_y = (PIX_W+3)'(left_diff) + ((PIX_W+3)'(centre_diff) <<< 1)
               + (PIX_W+3)'(right_diff);
        abs_x  = grad_x[PIX_W+2] ? (PIX_W+2)'(-grad_x) : (PIX_W+2)'(grad_x);
        abs_y  = grad_y[PIX_W+2] ? (PIX_W+2)'(-grad_y) : (PIX_W+2)'(grad_y);
        mag_sum = (PIX_W+3)'(abs_x) + (PIX_W+3)'(abs_y);
        if (s1_border_reg) begin
            edge_val = '0;
        end else if (mag_sum > (PIX_W+3)'(EDGE_MAX)) begin
            edge_val = EDGE_MAX;
        end else begin
            edge_val = mag_sum[PIX_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    logic [TDATA_OUT_W-1:0] m_data_reg;
    logic                   m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s1_leave && s1_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_leave && s1_emit_reg) begin
            m_data_reg <= {(TDATA_OUT_W - PIX_W - 2*OUT_XY_W)'(0),
                           OUT_XY_W'(s1_cy_reg), OUT_XY_W'(s1_cx_reg), edge_val};
            m_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // ------------------------------------------------------------------
    // Assertions.
    a_rise_from_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s1_valid_reg))
        else $error("result word appeared without a word in the read stage");

    a_border_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_leave && s1_emit_reg && s1_border_reg) |=> (m_valid_reg && m_data_reg[PIX_W-1:0] == '0))
        else $error("border result is not zero");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (s1_valid_reg && m_valid_reg && !m_tready))
        else $error("input stalled without a full pipeline");

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (EWW'(col_count_reg) < EWW'(MAX_WIDTH)) && (EWH'(row_count_reg) < EWH'(MAX_HEIGHT)))
        else $error("position counter beyond line buffer depth");

endmodule

`default_nettype wire

// File: dv/sem_edge_checker.sv
// Checker for the Sobel edge magnitude block: watches the pixel, result and APB channels.
// Keeps its own line buffers, window and counters, and compares every result word.
// Depends on sem_pkg for widths, limits and register indexes.
`timescale 1ns / 1ps

module sem_edge_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [sem_pkg::TDATA_IN_W-1:0]     s_tdata,   // [7:0] pixel
    input  logic                               s_tuser,   // [0] frame_start
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [sem_pkg::TDATA_OUT_W-1:0]    m_tdata,   // [7:0] edge_value, [17:8] out_x,
                                                          // [27:18] out_y, rest 0
    input  logic                               m_tlast,   // [0] frame_last
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sem_pkg::APB_AW-1:0]         paddr,
    input  logic [sem_pkg::APB_DW-1:0]         pwdata,
    input  logic                               pready,
    output int                                 fail_count,
    output int                                 pending_count,
    output int                                 result_count
);

    localparam int MAX_W = sem_pkg::MAX_WIDTH_DEF;
    localparam int MAX_H = sem_pkg::MAX_HEIGHT_DEF;

    // One expected result word, fields from the highest bit down.
    typedef struct packed {
        logic                           frame_last;
        logic [sem_pkg::OUT_XY_W-1:0]   out_y;
        logic [sem_pkg::OUT_XY_W-1:0]   out_x;
        logic [sem_pkg::PIX_W-1:0]      grad_mag;
    } edge_result_t;

    edge_result_t               expected_edges[$];

    // Shadow of the block: two previous rows, the two columns to the left, the position.
    logic [sem_pkg::PIX_W-1:0]  row_above[MAX_W];
    logic [sem_pkg::PIX_W-1:0]  row_above2[MAX_W];
    logic [sem_pkg::PIX_W-1:0]  win_px[6];     // [0..2] column x-2, [3..5] column x-1
    int unsigned                col_pos;
    int unsigned                row_pos;
    logic [sem_pkg::CFG_W-1:0]  width_reg;
    logic [sem_pkg::CFG_W-1:0]  height_reg;

    initial begin
        fail_count    = 0;
        pending_count = 0;
        result_count  = 0;
    end

    // Dimension as the block uses it, saturated into its legal range.
    function automatic int unsigned dim_in_use(input logic [sem_pkg::CFG_W-1:0] v,
                                               input int unsigned hi);
        if (v < sem_pkg::MIN_DIM) return sem_pkg::MIN_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    always @(posedge aclk) begin : predict_and_compare
        int unsigned                w, h, x, y, xi, cx, cy;
        int                         dx, dy, mag;
        logic [sem_pkg::PIX_W-1:0]  t, m, b;
        edge_result_t               want;

        if (!aresetn) begin
            for (int i = 0; i < MAX_W; i++) begin
                row_above[i]  = '0;
                row_above2[i] = '0;
            end
            for (int i = 0; i < 6; i++) win_px[i] = '0;
            col_pos    = 0;
            row_pos    = 0;
            width_reg  = sem_pkg::DIM_RESET;
            height_reg = sem_pkg::DIM_RESET;
            expected_edges.delete();
        end else begin
            // Result words are compared first: they belong to earlier pixels.
            if (m_tvalid && m_tready) begin
                result_count++;
                if (expected_edges.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result word %h last %0b arrived with nothing expected",
                                 $time, m_tdata, m_tlast);
                end else begin
                    want = expected_edges.pop_front();
                    if (m_tdata[7:0] !== want.grad_mag || m_tdata[17:8] !== want.out_x ||
                        m_tdata[27:18] !== want.out_y || m_tdata[31:28] !== 4'h0 ||
                        m_tlast !== want.frame_last) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%0t: expected value %0d at (%0d,%0d) last %0b, ",
                                      "got value %0d at (%0d,%0d) last %0b pad %h"},
                                     $time, want.grad_mag, want.out_x, want.out_y,
                                     want.frame_last, m_tdata[7:0], m_tdata[17:8],
                                     m_tdata[27:18], m_tlast, m_tdata[31:28]);
                    end
                end
            end

            // An accepted pixel moves the window and may complete one centre.
            if (s_tvalid && s_tready) begin
                w = dim_in_use(width_reg, MAX_W);
                h = dim_in_use(height_reg, MAX_H);
                if (s_tuser) begin
                    col_pos = 0;
                    row_pos = 0;
                end
                x  = col_pos;
                y  = row_pos;
                xi = (x < MAX_W) ? x : MAX_W - 1;
                t  = row_above2[xi];
                m  = row_above[xi];
                b  = s_tdata[7:0];

                if (x >= 1 && y >= 1) begin
                    cx  = x - 1;
                    cy  = y - 1;
                    mag = 0;
                    // The top row and the left column of the image are held at zero.
                    if (cx != 0 && cy != 0) begin
                        dx = (int'(win_px[0]) + 2 * int'(win_px[1]) + int'(win_px[2])) -
                             (int'(t) + 2 * int'(m) + int'(b));
                        dy = (int'(win_px[0]) + 2 * int'(win_px[3]) + int'(t)) -
                             (int'(win_px[2]) + 2 * int'(win_px[5]) + int'(b));
                        mag = (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
                        if (mag > int'(sem_pkg::EDGE_MAX)) mag = sem_pkg::EDGE_MAX;
                    end
                    want.grad_mag   = 8'(mag);
                    want.out_x      = 10'(cx);
                    want.out_y      = 10'(cy);
                    want.frame_last = (x + 1 >= w && y + 1 >= h);
                    expected_edges.push_back(want);
                end

                win_px[0] = win_px[3];
                win_px[1] = win_px[4];
                win_px[2] = win_px[5];
                win_px[3] = t;
                win_px[4] = m;
                win_px[5] = b;
                row_above2[xi] = m;
                row_above[xi]  = b;

                // Column wraps at the width, row at the height.
                if (x + 1 >= w) begin
                    col_pos = 0;
                    row_pos = (y + 1 >= h) ? 0 : y + 1;
                end else begin
                    col_pos = x + 1;
                end
            end

            // Register writes as the block sees them.
            if (psel && penable && pwrite && pready) begin
                case (paddr[2])
                    sem_pkg::REG_IMAGE_WIDTH:  width_reg  = pwdata[sem_pkg::CFG_W-1:0];
                    sem_pkg::REG_IMAGE_HEIGHT: height_reg = pwdata[sem_pkg::CFG_W-1:0];
                    default: ;
                endcase
            end
        end
        pending_count = expected_edges.size();
    end

endmodule

// File: dv/testbench.sv
// Top of the Sobel edge magnitude testbench: clock, reset, pixel and APB stimulus, verdict.
// Depends on sem_pkg, the sobel_edge_magnitude block and the sem_edge_checker module.
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 300000;

    logic                               aclk     = 1'b0;
    logic                               aresetn  = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [sem_pkg::TDATA_IN_W-1:0]     s_tdata  = '0;   // [7:0] pixel
    logic                               s_tuser  = 1'b0; // [0] frame_start
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [sem_pkg::TDATA_OUT_W-1:0]    m_tdata;         // [7:0] edge_value, [17:8] out_x,
                                                         // [27:18] out_y, rest 0
    logic                               m_tlast;         // [0] frame_last
    logic                               psel     = 1'b0;
    logic                               penable  = 1'b0;
    logic                               pwrite   = 1'b0;
    logic [sem_pkg::APB_AW-1:0]         paddr    = '0;
    logic [sem_pkg::APB_DW-1:0]         pwdata   = '0;
    logic [sem_pkg::APB_DW-1:0]         prdata;
    logic                               pready;

    int fail_count;
    int pending_count;
    int result_count;

    int items_sent   = 0;
    int random_items = 0;
    int cfg_writes   = 0;
    int cycle_count  = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    // Stimulus variables for the random phases.
    int ew, eh, nframes, flen, phase_items;
    logic [sem_pkg::CFG_W-1:0] wreg, hreg;
    bit carry_on, mark;

    sobel_edge_magnitude u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    sem_edge_checker u_edge_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .result_count  (result_count)
    );

    always #1 aclk = ~aclk;

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    // Result receiver: one long hold-off once traffic is flowing, a stretch that
    // never stalls, random stalls elsewhere.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && result_count >= 400) begin
            hold_done = 1'b1;
            hold_left = 399;
            m_tready <= 1'b0;
        end else if (result_count >= 2200 && result_count < 2500) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= 33);
        end
    end

    // Pixel value, biased towards the extremes so that saturation comes up often.
    function automatic logic [7:0] next_pixel();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
        return 8'($urandom_range(0, 255));
    endfunction

    // Offer one pixel word, with random gaps in front; called and left at a falling edge.
    task automatic send_pixel(input logic [7:0] pix, input logic frame_start);
        while (!(items_sent >= 3900 && items_sent < 4300) && $urandom_range(0, 99) < 33) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= frame_start;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        items_sent++;
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic idx, input logic [sem_pkg::CFG_W-1:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(sem_pkg::APB_DW - sem_pkg::CFG_W){1'b0}}, val};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_writes++;
    endtask

    // Stop offering and let every expected word out, plus the pipeline depth.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset dimensions of 1024 by 1024: two full rows and part of a third, so
        // that centres 1 to 58 of row 1 carry real gradients and both line buffers fill.
        for (int p = 0; p < 2108; p++) send_pixel(next_pixel(), p == 0);
        wait_drained();

        // Smallest image, reached through register values below the legal range;
        // a bright left column saturates the horizontal gradient.
        write_reg(sem_pkg::REG_IMAGE_WIDTH, 11'd0);
        write_reg(sem_pkg::REG_IMAGE_HEIGHT, 11'd2);
        for (int p = 0; p < 9; p++) send_pixel((p % 3 == 0) ? 8'd255 : 8'd0, p == 0);
        // Without a frame start the counters run on into the next image.
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);
        // A frame start in the middle of a row restarts at the origin.
        send_pixel(8'd128, 1'b1);
        wait_drained();

        // Width shrunk in the middle of an image: the column past the new limit
        // still yields a result and then wraps.
        write_reg(sem_pkg::REG_IMAGE_WIDTH, 11'd4);
        for (int p = 0; p < 11; p++) send_pixel(next_pixel(), p == 0);
        wait_drained();
        write_reg(sem_pkg::REG_IMAGE_WIDTH, 11'd3);
        send_pixel(next_pixel(), 1'b0);
        send_pixel(next_pixel(), 1'b0);
        wait_drained();

        // Tall narrow image, height register above the legal range.
        write_reg(sem_pkg::REG_IMAGE_WIDTH, 11'd1);
        write_reg(sem_pkg::REG_IMAGE_HEIGHT, 11'd2047);
        for (int p = 0; p < 1560; p++) send_pixel(next_pixel(), p == 0);
        wait_drained();

        // Random phases: mostly whole frames of small images, with truncated
        // frames, stray frame starts and images carried across a register change.
        while (random_items < 1050) begin
            case ($urandom_range(0, 19))
                0:       ew = sem_pkg::MAX_WIDTH_DEF;
                1, 2, 3: ew = $urandom_range(13, 64);
                default: ew = $urandom_range(3, 12);
            endcase
            case ($urandom_range(0, 19))
                0:       eh = sem_pkg::MAX_HEIGHT_DEF;
                1, 2:    eh = $urandom_range(9, 30);
                default: eh = $urandom_range(3, 8);
            endcase
            wreg = ew[10:0];
            hreg = eh[10:0];
            if (ew == 3 && $urandom_range(0, 1)) wreg = $urandom_range(0, 2);
            if (eh == 3 && $urandom_range(0, 1)) hreg = $urandom_range(0, 2);
            if (ew == sem_pkg::MAX_WIDTH_DEF && $urandom_range(0, 1))
                wreg = $urandom_range(1025, 2047);
            if (eh == sem_pkg::MAX_HEIGHT_DEF && $urandom_range(0, 1))
                hreg = $urandom_range(1025, 2047);
            write_reg(sem_pkg::REG_IMAGE_WIDTH, wreg);
            write_reg(sem_pkg::REG_IMAGE_HEIGHT, hreg);

            carry_on    = ($urandom_range(0, 99) < 30);
            nframes     = $urandom_range(1, 4);
            phase_items = 0;
            for (int f = 0; f < nframes && phase_items < 200; f++) begin
                flen = ew * eh;
                if ($urandom_range(0, 99) < 15) flen = $urandom_range(1, flen - 1);
                mark = (f == 0) ? !carry_on : ($urandom_range(0, 99) >= 10);
                for (int p = 0; p < flen && phase_items < 200; p++) begin
                    send_pixel(next_pixel(), (p == 0 && mark) || $urandom_range(0, 199) == 0);
                    phase_items++;
                    random_items++;
                end
            end
            wait_drained();
        end

        $display("Pixels sent: %0d (%0d in random phases), result words checked: %0d,",
                 items_sent, random_items, result_count);
        $display("register writes: %0d, mismatches: %0d, left outstanding: %0d",
                 cfg_writes, fail_count, pending_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
